// ----- sv/hss_pkg.sv -----
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types and constants for the five-point heat stencil sweep.
// ----------------------------------------------------------------------------
package hss_pkg;

    // cell values: signed Q16.16
    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ROUND_HALF = 32768;

    localparam int COEF_W  = 16;
    localparam int THR_W   = 31;
    localparam int COUNT_W = 16;

    // configuration port
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_WIDTH_W  = 6;
    localparam int CFG_HEIGHT_W = 12;

    localparam int MIN_DIM          = 3;
    localparam int CFG_WIDTH_RESET  = 32;
    localparam int CFG_HEIGHT_RESET = 32;
    localparam int COEF_V_RESET     = 6554;
    localparam int COEF_H_RESET     = 6554;
    localparam int THRESH_RESET     = 9830;

    localparam int DEF_MAX_WIDTH  = 63;
    localparam int DEF_MAX_HEIGHT = 4095;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_WIDTH       = 3'd0,
        CFG_GRID_HEIGHT      = 3'd1,
        CFG_COEF_VERTICAL    = 3'd2,
        CFG_COEF_HORIZONTAL  = 3'd3,
        CFG_CHANGE_THRESHOLD = 3'd4
    } t_cfg_index;

    typedef enum logic {
        ST_RUN   = 1'b0,
        ST_FLUSH = 1'b1
    } t_sweep_state;

    // control that travels with each beat down the pipeline
    typedef struct packed {
        logic valid;     // beat produces a result
        logic last;      // final result of the grid
        logic interior;  // apply the stencil, else pass through
        logic upd;       // beat came from the input (not a flush beat)
    } t_beat_ctl;

endpackage

// ----- sv/hss_ram.sv -----
// ----------------------------------------------------------------------------
// hss_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module hss_ram import hss_pkg::*; #(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = DEF_MAX_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read sees the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/hss_arith.sv -----
// ----------------------------------------------------------------------------
// hss_arith
// Five-stage stencil datapath: Laplacian terms, coefficient products,
// rounding, saturation, and the change-against-threshold test.
// ----------------------------------------------------------------------------
module hss_arith import hss_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_beat_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_centre,
    input  logic signed [DATA_W-1:0] i_up,
    input  logic signed [DATA_W-1:0] i_down,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    input  logic [COEF_W-1:0]        i_coef_v,
    input  logic [COEF_W-1:0]        i_coef_h,
    input  logic [THR_W-1:0]         i_thresh,
    output t_beat_ctl                o_ctl,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_exceeded
);

    localparam int DIFF_W = DATA_W + 2;
    localparam int PROD_W = DIFF_W + COEF_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - FRAC_BITS;
    localparam int NEW_W  = Q_W + 1;
    localparam int MAG_W  = DATA_W + 1;

    // stage A: second differences
    t_beat_ctl                r_a_ctl;
    logic signed [DIFF_W-1:0] r_a_dv, r_a_dh, n_a_dv, n_a_dh;
    logic signed [DATA_W-1:0] r_a_old;

    // stage B: products
    t_beat_ctl                r_b_ctl;
    logic signed [PROD_W-1:0] r_b_pv, r_b_ph, n_b_pv, n_b_ph;
    logic signed [DATA_W-1:0] r_b_old;

    // stage C: rounded Q16.16 increment
    t_beat_ctl                r_c_ctl;
    logic signed [SUM_W-1:0]  n_c_sum;
    logic signed [Q_W-1:0]    r_c_q, n_c_q;
    logic signed [DATA_W-1:0] r_c_old;

    // stage D: new value, saturated
    t_beat_ctl                r_d_ctl;
    logic signed [NEW_W-1:0]  n_d_wide;
    logic signed [DATA_W-1:0] r_d_new, n_d_new, r_d_old;
    logic                     n_d_hi_ones, n_d_hi_zeros;

    // stage E: change test
    t_beat_ctl                r_e_ctl;
    logic signed [MAG_W-1:0]  n_e_diff;
    logic [MAG_W-1:0]         n_e_mag;
    logic                     r_e_ex, n_e_ex;
    logic signed [DATA_W-1:0] r_e_new;

    always_comb begin
        if (i_ctl.interior) begin
            n_a_dv = DIFF_W'(i_up) + DIFF_W'(i_down) - (DIFF_W'(i_centre) <<< 1);
            n_a_dh = DIFF_W'(i_left) + DIFF_W'(i_right) - (DIFF_W'(i_centre) <<< 1);
        end else begin
            n_a_dv = '0;
            n_a_dh = '0;
        end
    end

    always_comb begin
        n_b_pv = PROD_W'($signed({1'b0, i_coef_v})) * PROD_W'(r_a_dv);
        n_b_ph = PROD_W'($signed({1'b0, i_coef_h})) * PROD_W'(r_a_dh);
    end

    // floor((s + half) / 2^16): round to nearest, ties upward
    always_comb begin
        n_c_sum = SUM_W'(r_b_pv) + SUM_W'(r_b_ph) + SUM_W'(ROUND_HALF);
        n_c_q   = Q_W'(n_c_sum >>> FRAC_BITS);
    end

    always_comb begin
        n_d_wide     = NEW_W'(r_c_old) + NEW_W'(r_c_q);
        n_d_hi_ones  = &n_d_wide[NEW_W-1:DATA_W-1];
        n_d_hi_zeros = ~|n_d_wide[NEW_W-1:DATA_W-1];
        if (n_d_hi_ones || n_d_hi_zeros) begin
            n_d_new = n_d_wide[DATA_W-1:0];
        end else if (n_d_wide[NEW_W-1]) begin
            n_d_new = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            n_d_new = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_comb begin
        n_e_diff = MAG_W'(r_d_new) - MAG_W'(r_d_old);
        n_e_mag  = n_e_diff[MAG_W-1] ? MAG_W'(-n_e_diff) : MAG_W'(n_e_diff);
        n_e_ex   = n_e_mag > MAG_W'(i_thresh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
            r_c_ctl <= '0;
            r_d_ctl <= '0;
            r_e_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
            r_c_ctl <= r_b_ctl;
            r_d_ctl <= r_c_ctl;
            r_e_ctl <= r_d_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_dv  <= n_a_dv;
            r_a_dh  <= n_a_dh;
            r_a_old <= i_centre;
            r_b_pv  <= n_b_pv;
            r_b_ph  <= n_b_ph;
            r_b_old <= r_a_old;
            r_c_q   <= n_c_q;
            r_c_old <= r_b_old;
            r_d_new <= n_d_new;
            r_d_old <= r_c_old;
            r_e_new <= r_d_new;
            r_e_ex  <= n_e_ex;
        end
    end

    assign o_ctl      = r_e_ctl;
    assign o_value    = r_e_new;
    assign o_exceeded = r_e_ex;

endmodule

// ----- sv/heat_stencil_sweep.sv -----
// ----------------------------------------------------------------------------
// heat_stencil_sweep
// Pipeline: a beat passes stage 1, datapath stages A to E and the output
//   register; results trail the input by one grid row.
// Throughput: one cell per cycle while the output is not stalled; the last
//   cell of a sweep is followed by stalled input while the last row drains from the store.
// Reset: synchronous, active low; clears control and loads register defaults.
// ----------------------------------------------------------------------------
module heat_stencil_sweep import hss_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // cell input
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_cell_value,
    // result output
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_new_value,
    output logic                     o_change_exceeded,
    output logic [COUNT_W-1:0]       o_exceed_count,
    output logic                     o_sweep_end,
    // register writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RST_LAST_COL =
        ((CFG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RESET) - 1;
    localparam int RST_LAST_ROW =
        ((CFG_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_HEIGHT_RESET) - 1;

    // registers
    logic [COL_W-1:0]  r_last_col, n_last_col;
    logic [ROW_W-1:0]  r_last_row, n_last_row;
    logic [COEF_W-1:0] r_coef_v, r_coef_h;
    logic [THR_W-1:0]  r_thresh;
    logic [CFG_WIDTH_W-1:0]  cfg_w;
    logic [CFG_HEIGHT_W-1:0] cfg_h;
    logic              cfg_we, cfg_restart;

    // sweep position and flush sequencing
    logic [COL_W-1:0]  r_col, r_flush_col;
    logic [ROW_W-1:0]  r_row;
    t_sweep_state      r_state, n_state;
    logic              flush_active;

    logic              adv, in_accept, last_cell, interior;
    logic [COL_W-1:0]  mid_a_addr, right_addr;

    // line stores
    logic signed [DATA_W-1:0] mid_a_rdata, mid_b_rdata, up_rdata;

    // stage 1: beside the store read data
    t_beat_ctl                r_s1_ctl, n_s1_ctl;
    logic signed [DATA_W-1:0] r_s1_x, r_left;
    logic [COL_W-1:0]         r_s1_col;

    // datapath tail
    t_beat_ctl                e_ctl;
    logic signed [DATA_W-1:0] e_value;
    logic                     e_ex;

    // output stage
    logic                     r_out_valid, r_out_ex, r_out_end;
    logic signed [DATA_W-1:0] r_out_value;
    logic [COUNT_W-1:0]       r_out_count, r_count, n_count;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign cfg_w       = i_cfg_data[CFG_WIDTH_W-1:0];
    assign cfg_h       = i_cfg_data[CFG_HEIGHT_W-1:0];
    assign cfg_restart = cfg_we && ((t_cfg_index'(i_cfg_index) == CFG_GRID_WIDTH) ||
                                    (t_cfg_index'(i_cfg_index) == CFG_GRID_HEIGHT));

    always_comb begin
        if (int'(cfg_w) < MIN_DIM) begin
            n_last_col = COL_W'(MIN_DIM - 1);
        end else if (int'(cfg_w) > MAX_WIDTH) begin
            n_last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            n_last_col = COL_W'(cfg_w - 1'b1);
        end
        if (int'(cfg_h) < MIN_DIM) begin
            n_last_row = ROW_W'(MIN_DIM - 1);
        end else if (int'(cfg_h) > MAX_HEIGHT) begin
            n_last_row = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            n_last_row = ROW_W'(cfg_h - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= COL_W'(RST_LAST_COL);
            r_last_row <= ROW_W'(RST_LAST_ROW);
            r_coef_v   <= COEF_W'(COEF_V_RESET);
            r_coef_h   <= COEF_W'(COEF_H_RESET);
            r_thresh   <= THR_W'(THRESH_RESET);
        end else if (cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_GRID_WIDTH:       r_last_col <= n_last_col;
                CFG_GRID_HEIGHT:      r_last_row <= n_last_row;
                CFG_COEF_VERTICAL:    r_coef_v   <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_HORIZONTAL:  r_coef_h   <= i_cfg_data[COEF_W-1:0];
                CFG_CHANGE_THRESHOLD: r_thresh   <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake and flush sequencer ----------------
    // whole pipeline moves when the output register can take a beat
    assign adv       = !r_out_valid || !i_stall;
    assign o_stall   = !adv || flush_active;
    assign in_accept = i_valid && !o_stall;
    assign last_cell = (r_row == r_last_row) && (r_col == r_last_col);
    assign interior  = (r_row > ROW_W'(1)) && (r_col != '0) && (r_col != r_last_col);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (in_accept && last_cell) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (adv && (r_flush_col == r_last_col)) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        flush_active = (r_state == ST_FLUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_flush_col <= '0;
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            r_state <= n_state;
            if (flush_active && adv) begin
                r_flush_col <= (r_flush_col == r_last_col) ? '0 : r_flush_col + 1'b1;
            end
            if (cfg_restart || (in_accept && last_cell)) begin
                r_row <= '0;
                r_col <= '0;
            end else if (in_accept) begin
                if (r_col == r_last_col) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // ---------------- line stores ----------------
    // the middle row is kept twice so centre and right neighbour read together
    assign mid_a_addr = flush_active ? r_flush_col : r_col;
    assign right_addr = (r_col == r_last_col) ? r_col : r_col + 1'b1;

    hss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_mid_a (
        .i_clk   (i_clk),
        .i_we    (in_accept),
        .i_waddr (r_col),
        .i_wdata (i_cell_value),
        .i_re    (adv),
        .i_raddr (mid_a_addr),
        .o_rdata (mid_a_rdata)
    );

    hss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_mid_b (
        .i_clk   (i_clk),
        .i_we    (in_accept),
        .i_waddr (r_col),
        .i_wdata (i_cell_value),
        .i_re    (adv),
        .i_raddr (right_addr),
        .o_rdata (mid_b_rdata)
    );

    // the old middle value drops into the upper row once its beat leaves stage 1
    hss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (adv && r_s1_ctl.valid && r_s1_ctl.upd),
        .i_waddr (r_s1_col),
        .i_wdata (mid_a_rdata),
        .i_re    (adv),
        .i_raddr (r_col),
        .o_rdata (up_rdata)
    );

    // ---------------- stage 1 ----------------
    always_comb begin
        n_s1_ctl = '0;
        if (flush_active) begin
            n_s1_ctl.valid = 1'b1;
            n_s1_ctl.last  = (r_flush_col == r_last_col);
        end else if (in_accept) begin
            n_s1_ctl.valid    = (r_row != '0);
            n_s1_ctl.interior = interior;
            n_s1_ctl.upd      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (adv) begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_x   <= i_cell_value;
            r_s1_col <= mid_a_addr;
        end
        // left neighbour is the previous beat's centre
        if (adv && r_s1_ctl.valid) begin
            r_left <= mid_a_rdata;
        end
    end

    hss_arith u_arith (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_ctl      (r_s1_ctl),
        .i_centre   (mid_a_rdata),
        .i_up       (up_rdata),
        .i_down     (r_s1_x),
        .i_left     (r_left),
        .i_right    (mid_b_rdata),
        .i_coef_v   (r_coef_v),
        .i_coef_h   (r_coef_h),
        .i_thresh   (r_thresh),
        .o_ctl      (e_ctl),
        .o_value    (e_value),
        .o_exceeded (e_ex)
    );

    // ---------------- output stage ----------------
    assign n_count = (e_ex && (r_count != '1)) ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= e_ctl.valid;
            end
            if (cfg_restart) begin
                r_count <= '0;
            end else if (adv && e_ctl.valid) begin
                r_count <= e_ctl.last ? '0 : n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && e_ctl.valid) begin
            r_out_value <= e_value;
            r_out_ex    <= e_ex;
            r_out_count <= n_count;
            r_out_end   <= e_ctl.last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_new_value       = r_out_value;
    assign o_change_exceeded = r_out_ex;
    assign o_exceed_count    = r_out_count;
    assign o_sweep_end       = r_out_end;

endmodule

// ----- sv/hss_checker.sv -----
// ----------------------------------------------------------------------------
// hss_checker
// Port-level checks for the heat stencil sweep, bound to the top level.
// ----------------------------------------------------------------------------
module hss_checker import hss_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [DATA_W-1:0] o_new_value,
    input logic                     o_change_exceeded,
    input logic [COUNT_W-1:0]       o_exceed_count,
    input logic                     o_sweep_end,
    input logic                     i_cfg_valid,
    input logic                     o_cfg_ready,
    input logic [CFG_INDEX_W-1:0]   i_cfg_index
);

    logic               out_beat, cfg_restart;
    logic               r_restart;
    logic [COUNT_W-1:0] r_prev_count, exp_count;

    assign out_beat    = o_valid && !i_stall;
    assign cfg_restart = i_cfg_valid && o_cfg_ready &&
                         ((t_cfg_index'(i_cfg_index) == CFG_GRID_WIDTH) ||
                          (t_cfg_index'(i_cfg_index) == CFG_GRID_HEIGHT));

    // running count model: restarts after reset, a dimension write or a sweep end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restart    <= 1'b1;
            r_prev_count <= '0;
        end else if (cfg_restart) begin
            r_restart <= 1'b1;
        end else if (out_beat) begin
            r_restart    <= o_sweep_end;
            r_prev_count <= o_exceed_count;
        end
    end

    always_comb begin
        if (r_restart) begin
            exp_count = COUNT_W'(o_change_exceeded);
        end else if (o_change_exceeded && (r_prev_count != '1)) begin
            exp_count = r_prev_count + 1'b1;
        end else begin
            exp_count = r_prev_count;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_new_value) &&
            $stable(o_exceed_count) && $stable(o_sweep_end)))
        else $error("result beat changed while stalled");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> (o_exceed_count == exp_count))
        else $error("exceed count does not follow the flagged beats");

    a_end_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sweep_end) |-> !o_change_exceeded)
        else $error("border cell at sweep end flagged as changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat straight after reset");

endmodule

bind heat_stencil_sweep hss_checker u_hss_checker (.*);
